@@ rtl/core/bhr_pkg.sv @@
// Package for the bandwidth history rollup core: widths, defaults, codes.
// No dependencies; bhr_if, bhr_div and the top level refer to it by scope.
package bhr_pkg;
    localparam int DefRecentDepth = 256;
    localparam int DefWeekDays    = 7;
    localparam int DefYearWeeks   = 52;
    localparam logic [19:0] DayReset = 20'd86400;

    localparam logic [1:0] FnAdd  = 2'd0;
    localparam logic [1:0] FnRead = 2'd1;
    localparam logic [1:0] FnAvg  = 2'd2;
    localparam logic [1:0] FnNop  = 2'd3;

    localparam logic [1:0] RgRecent = 2'd0;
    localparam logic [1:0] RgDaily  = 2'd1;
    localparam logic [1:0] RgWeekly = 2'd2;
    localparam logic [1:0] RgNone   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] sample_bw;
        logic [39:0] time_sec;
        logic [1:0]  region;
        logic [7:0]  age;
    } t_req;

    typedef struct packed {
        logic [31:0] value;
        logic        valid_res;
        logic [8:0]  recent_count;
        logic        day_closed;
        logic [31:0] day_avg;
        logic        week_closed;
        logic [31:0] week_avg;
        logic        dropped;
    } t_rsp;

    // Divider handshake.
    typedef struct packed {
        logic        start;
    } t_div_ctl;
endpackage

@@ rtl/core/bhr_if.sv @@
// Valid/ready channel interface carrying a payload of type T.
// Depends on bhr_pkg for the payload types.
interface bhr_if #(parameter type T = bhr_pkg::t_req) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bhr_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module bhr_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/core/bhr_div.sv @@
// Shared radix-2 restoring divider: 64-bit dividend by 32-bit divisor.
// Full 64-bit quotient and 32-bit remainder; used for day, week, average and day start.
module bhr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  bhr_pkg::t_div_ctl i_ctl,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quo,
    output logic [31:0] o_rem
);
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d, n_d;
    logic [32:0] w_sh, w_df;

    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        n_r   = r_r;
        n_d   = r_d;
        w_sh  = {r_r[31:0], r_q[63]};
        w_df  = w_sh - {1'b0, r_d};
        if (i_ctl.start) begin
            n_cnt = 7'd64;
            n_q   = i_num;
            n_r   = '0;
            n_d   = i_den;
        end else if (r_cnt != 7'd0) begin
            n_cnt = r_cnt - 7'd1;
            if (!w_df[32]) begin
                n_r = w_df;
                n_q = {r_q[62:0], 1'b1};
            end else begin
                n_r = w_sh;
                n_q = {r_q[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quo  = r_q;
    assign o_rem  = r_r[31:0];

    property p_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.start |-> !o_busy;
    endproperty
    a_idle: assert property (p_idle) else $error("divider restarted while busy");
    property p_run;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.start |=> r_cnt == 7'd64;
    endproperty
    a_run: assert property (p_run) else $error("divider did not load");
    property p_dec;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_cnt != 7'd0 && !i_ctl.start) |=> r_cnt == $past(r_cnt) - 7'd1;
    endproperty
    a_dec: assert property (p_dec) else $error("divider count skipped");
    property p_den;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.start |-> i_den != 32'd0;
    endproperty
    a_den: assert property (p_den) else $error("divide by zero");
endmodule

@@ rtl/core/bandwidth_history_rollup_core.sv @@
// Top level of the bandwidth history rollup: sequencer, stores, divider.
// Depends on bhr_pkg, bhr_if, bhr_ram and bhr_div.
//
// Use: one request channel (in, sink) and one response channel (out,
// source), both valid/ready; a beat moves on a clock edge where both are
// high. Every request beat gives exactly one response beat, in order. A
// configuration write (i_cfg_we, i_cfg_data) sets the day length; issue it
// only while no request is in flight.
// Path through the sequencer, from the accepting edge to the response:
// an unknown function goes straight to the output state; a sample inside
// the day passes the classify state, a daily read the region read state,
// a recent or weekly read also the RAM data state (registered RAM read).
// A day close realigns the day start on the 64-step divider, sums the
// recent store one RAM word a cycle and divides again for the average. A
// week close then sums the daily ring one day a cycle and divides once
// more. A rounded mean sums and divides without the realignment. The
// sequencer works one request at a time, and the next request is taken
// in the cycle after the response is registered.
// Reset clears all counters, the day start, the daily ring (through valid
// bits) and the weekly ring (through its fill count); the recent RAM needs
// no clearing. While the receiver stalls, the response register holds; one
// more request may be taken and worked, and its response waits for the
// register to free.
module bandwidth_history_rollup_core #(
    parameter int RECENT_DEPTH = bhr_pkg::DefRecentDepth,
    parameter int WEEK_DAYS    = bhr_pkg::DefWeekDays,
    parameter int YEAR_WEEKS   = bhr_pkg::DefYearWeeks
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_data,
    bhr_if.sink         in,
    bhr_if.source       out
);
    localparam int AW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int LW = $clog2(RECENT_DEPTH + 1);
    localparam int DW = (WEEK_DAYS > 1) ? $clog2(WEEK_DAYS) : 1;
    localparam int CW = $clog2(WEEK_DAYS + 1);
    localparam int WW = (YEAR_WEEKS > 1) ? $clog2(YEAR_WEEKS) : 1;
    localparam int KW = $clog2(YEAR_WEEKS + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RDR   = 11'b00000000010,
        S_SUM   = 11'b00000000100,
        S_DSTRT = 11'b00000001000,
        S_DWAIT = 11'b00000010000,
        S_AVG   = 11'b00000100000,
        S_AWAIT = 11'b00001000000,
        S_WSUM  = 11'b00010000000,
        S_WWAIT = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_RDD   = 11'b10000000000
    } t_state;

    t_state r_st, n_st;
    bhr_pkg::t_req r_req, n_req;
    bhr_pkg::t_rsp r_rsp, n_rsp;
    bhr_pkg::t_rsp r_out;
    logic          r_ov, n_ov;
    logic [19:0]   r_day_sec;
    logic [LW-1:0] r_len, n_len, r_cnt, n_cnt;
    logic [CW-1:0] r_dcnt, n_dcnt;
    logic [KW-1:0] r_wcnt, n_wcnt;
    logic          r_wfull;
    logic [39:0]   r_dstart, n_dstart;
    logic [31:0]   r_daily [WEEK_DAYS];
    logic          r_dval  [WEEK_DAYS];
    logic [LW-1:0] r_idx, n_idx;
    logic [63:0]   r_sum, n_sum;
    logic [31:0]   r_davg, n_davg;
    logic          r_rnd, n_rnd;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_wdata, w_rdata;
    logic [WW-1:0] w_waddr;
    logic [31:0]   w_wkq;
    bhr_pkg::t_div_ctl w_dctl;
    logic [63:0]   w_num;
    logic [31:0]   w_den;
    logic          w_busy;
    logic [63:0]   w_quo;
    logic [31:0]   w_rem;
    logic [19:0]   w_len;
    logic [39:0]   w_dt;
    logic          w_inday;
    logic [LW+8:0] w_rtmp;
    logic [LW-1:0] w_ridx;
    logic [DW-1:0] w_dpos;
    logic [WW-1:0] w_wpos;
    logic [CW+8:0] w_dtmp;
    logic [KW+8:0] w_wtmp;
    logic          w_wclose;
    logic [DW-1:0] w_dwr;
    logic          w_dwe, w_wwe;
    logic          w_load;

    bhr_ram #(.Width(32), .Depth(RECENT_DEPTH)) u_recent (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    bhr_ram #(.Width(32), .Depth(YEAR_WEEKS)) u_weekly (
        .i_clk(i_clk), .i_we(w_wwe), .i_addr(w_waddr),
        .i_wdata(w_quo[31:0]), .o_rdata(w_wkq)
    );

    bhr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl), .i_num(w_num),
        .i_den(w_den), .o_busy(w_busy), .o_quo(w_quo), .o_rem(w_rem)
    );

    assign in.ready  = (r_st == S_IDLE);
    assign out.valid = r_ov;
    assign out.data  = r_out;

    assign w_len   = (r_day_sec == 20'd0) ? 20'd1 : r_day_sec;
    assign w_dt    = r_req.time_sec - r_dstart;
    assign w_inday = (r_req.time_sec > r_dstart) && (w_dt < {20'd0, w_len});
    // Ring position of an entry by age: (size + count - 1 - age) mod size.
    // Age is below the size, so the sum stays below twice the size.
    assign w_rtmp  = (LW+9)'(r_cnt) + (LW+9)'(r_len) - (LW+9)'(1) - (LW+9)'(r_req.age);
    assign w_ridx  = (w_rtmp >= (LW+9)'(r_len)) ? LW'(w_rtmp - (LW+9)'(r_len))
                                                : LW'(w_rtmp);
    assign w_dtmp  = (CW+9)'(WEEK_DAYS) + (CW+9)'(r_dcnt) - (CW+9)'(1) - (CW+9)'(r_req.age);
    assign w_wtmp  = (KW+9)'(YEAR_WEEKS) + (KW+9)'(r_wcnt) - (KW+9)'(1) - (KW+9)'(r_req.age);
    assign w_dpos  = (w_dtmp >= (CW+9)'(WEEK_DAYS)) ? DW'(w_dtmp - (CW+9)'(WEEK_DAYS))
                                                    : DW'(w_dtmp);
    assign w_wpos  = (w_wtmp >= (KW+9)'(YEAR_WEEKS)) ? WW'(w_wtmp - (KW+9)'(YEAR_WEEKS))
                                                     : WW'(w_wtmp);
    assign w_wclose = (r_dcnt >= CW'(WEEK_DAYS));

    always_comb begin
        n_st = r_st; n_req = r_req; n_rsp = r_rsp; n_ov = r_ov;
        n_len = r_len; n_cnt = r_cnt; n_dcnt = r_dcnt; n_wcnt = r_wcnt;
        n_dstart = r_dstart; n_idx = r_idx; n_sum = r_sum; n_davg = r_davg;
        n_rnd = r_rnd;
        w_we = 1'b0; w_addr = '0; w_wdata = r_req.sample_bw;
        w_dctl.start = 1'b0; w_num = r_sum; w_den = {12'd0, w_len};
        w_dwe = 1'b0; w_wwe = 1'b0; w_dwr = '0; w_waddr = w_wpos;
        w_load = 1'b0;
        if (out.valid && out.ready) begin
            n_ov = 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                if (in.valid && in.ready) begin
                    n_req = in.data;
                    n_rsp = '0;
                    n_idx = '0;
                    n_sum = '0;
                    n_rnd = 1'b0;
                    case (in.data.func)
                        bhr_pkg::FnAdd:  n_st = S_DSTRT;
                        bhr_pkg::FnRead: n_st = S_RDR;
                        bhr_pkg::FnAvg: begin
                            n_rnd = 1'b1;
                            n_st  = S_SUM;
                        end
                        default: n_st = S_OUT;
                    endcase
                end
            end
            S_DSTRT: begin
                // Classify the sample; a close first realigns the day start.
                if (w_inday) begin
                    if (r_cnt >= r_len) begin
                        if (r_len < LW'(RECENT_DEPTH)) begin
                            w_we   = 1'b1;
                            w_addr = AW'(r_len);
                            n_len  = r_len + LW'(1);
                            n_cnt  = r_cnt + LW'(1);
                        end else begin
                            n_rsp.dropped = 1'b1;
                        end
                    end else begin
                        w_we   = 1'b1;
                        w_addr = AW'(r_cnt);
                        n_cnt  = r_cnt + LW'(1);
                    end
                    n_st = S_OUT;
                end else begin
                    if (r_cnt < r_len) begin
                        n_len = r_cnt;
                    end
                    w_dctl.start = 1'b1;
                    w_num = {24'd0, r_req.time_sec};
                    n_st  = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (!w_busy) begin
                    n_dstart = r_req.time_sec - 40'(w_rem);
                    n_st     = S_SUM;
                end
            end
            S_SUM: begin
                // Address idx; the registered read returns its data in the next cycle.
                w_addr = AW'(r_idx);
                if (r_idx != '0) begin
                    n_sum = r_sum + 64'(w_rdata);
                end
                if (r_idx == r_len) begin
                    n_st = S_AVG;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            S_AVG: begin
                if (r_len != '0) begin
                    w_dctl.start = 1'b1;
                    w_den = 32'(r_len);
                    w_num = r_rnd ? r_sum + 64'(r_len >> 1) : r_sum;
                    n_st  = S_AWAIT;
                end else begin
                    n_davg = '0;
                    n_st   = r_rnd ? S_OUT : S_AWAIT;
                end
            end
            S_AWAIT: begin
                if (!w_busy) begin
                    if (r_rnd) begin
                        n_rsp.value     = w_quo[31:0];
                        n_rsp.valid_res = 1'b1;
                        n_st = S_OUT;
                    end else begin
                        n_davg = (r_len != '0) ? w_quo[31:0] : 32'd0;
                        n_rsp.day_closed = 1'b1;
                        n_rsp.day_avg    = (r_len != '0) ? w_quo[31:0] : 32'd0;
                        w_we   = 1'b1;
                        w_addr = '0;
                        if (r_len == '0) begin
                            n_len = LW'(1);
                        end
                        n_cnt = LW'(1);
                        n_idx = '0;
                        n_sum = '0;
                        if (w_wclose) begin
                            n_st = S_WSUM;
                        end else begin
                            w_dwe = 1'b1;
                            w_dwr = DW'(r_dcnt);
                            n_dcnt = r_dcnt + CW'(1);
                            n_st = S_OUT;
                        end
                    end
                end
            end
            S_WSUM: begin
                // The divider has no other user now; add one day a cycle.
                n_sum = r_sum + 64'(r_dval[DW'(r_idx)] ? r_daily[DW'(r_idx)] : 32'd0);
                if (r_idx == LW'(WEEK_DAYS - 1)) begin
                    w_dctl.start = 1'b1;
                    w_num = n_sum;
                    w_den = 32'(WEEK_DAYS);
                    n_st  = S_WWAIT;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            S_WWAIT: begin
                if (!w_busy) begin
                    n_dcnt  = CW'(1);
                    w_dwe   = 1'b1;
                    w_dwr   = '0;
                    w_wwe   = 1'b1;
                    w_waddr = (r_wcnt >= KW'(YEAR_WEEKS)) ? '0 : WW'(r_wcnt);
                    n_wcnt  = ((r_wcnt >= KW'(YEAR_WEEKS)) ? '0 : r_wcnt) + KW'(1);
                    n_rsp.week_closed = 1'b1;
                    n_rsp.week_avg    = w_quo[31:0];
                    n_st = S_OUT;
                end
            end
            S_RDR: begin
                n_st = S_OUT;
                case (r_req.region)
                    bhr_pkg::RgRecent: begin
                        // Address the RAM now, take its data in the next cycle.
                        if ((LW+8)'(r_req.age) < (LW+8)'(r_len)) begin
                            w_addr = AW'(w_ridx);
                            n_rsp.valid_res = 1'b1;
                            n_rnd = 1'b1;
                            n_st  = S_RDD;
                        end
                    end
                    bhr_pkg::RgDaily: begin
                        if (32'(r_req.age) < 32'(WEEK_DAYS)) begin
                            n_rsp.valid_res = 1'b1;
                            n_rsp.value = r_dval[w_dpos] ? r_daily[w_dpos] : 32'd0;
                        end
                    end
                    bhr_pkg::RgWeekly: begin
                        // Entries beyond the fill count still read as zero.
                        if (32'(r_req.age) < 32'(YEAR_WEEKS)) begin
                            w_waddr = w_wpos;
                            n_rsp.valid_res = 1'b1;
                            n_rnd = r_wfull || (KW'(w_wpos) < r_wcnt);
                            n_st  = S_RDD;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDD: begin
                if (r_rnd) begin
                    n_rsp.value = (r_req.region == bhr_pkg::RgRecent) ? w_rdata : w_wkq;
                end
                n_st = S_OUT;
            end
            S_OUT: begin
                // Load the response register once it is free or being drained.
                if (!r_ov || out.ready) begin
                    n_rsp.recent_count = 9'(r_len);
                    w_load = 1'b1;
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_day_sec <= bhr_pkg::DayReset;
            r_len <= '0; r_cnt <= '0; r_dcnt <= '0; r_wcnt <= '0; r_dstart <= '0;
            r_wfull <= 1'b0;
            for (int i = 0; i < WEEK_DAYS; i++) r_dval[i] <= 1'b0;
        end else begin
            r_st <= n_st; r_ov <= n_ov;
            if (i_cfg_we) begin
                r_day_sec <= i_cfg_data;
            end
            r_len <= n_len; r_cnt <= n_cnt; r_dcnt <= n_dcnt; r_wcnt <= n_wcnt;
            r_dstart <= n_dstart;
            if (r_wcnt == KW'(YEAR_WEEKS)) r_wfull <= 1'b1;
            if (w_dwe) r_dval[w_dwr] <= 1'b1;
        end
        r_req <= n_req; r_rsp <= n_rsp; r_idx <= n_idx; r_sum <= n_sum;
        r_davg <= n_davg; r_rnd <= n_rnd;
        if (w_load) r_out <= n_rsp;
        if (w_dwe) r_daily[w_dwr] <= n_davg;
    end

    property p_len;
        @(posedge i_clk) disable iff (!i_rst_n) r_len <= LW'(RECENT_DEPTH);
    endproperty
    a_len: assert property (p_len) else $error("recent length overflow");
    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (out.valid && !out.ready) |=> out.valid && $stable(r_out);
    endproperty
    a_hold: assert property (p_hold) else $error("response changed under stall");
    property p_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_st != S_IDLE) |-> !in.ready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready while busy");
endmodule
